// ----- hw/rtl/psu_pkg.sv -----
// Shared types, codes and the Paeth predictor for the PNG scanline unfilter.
// No dependencies; the top, front and back refer to this package by scoped name.
package psu_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned BPP_W       = 4;
  localparam int unsigned ROW_BYTES_W = 15;

  // PNG filter types; codes above Paeth are folded to None on entry.
  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filter_e;

  // One data byte handed from the front to the back (column travels beside it).
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    filter_e           filter;
    logic              first_row;
    logic              row_end;
  } entry_t;

  // Paeth predictor, ties go to a, then b, then c.
  function automatic logic [BYTE_W-1:0] paeth(input logic [BYTE_W-1:0] a,
                                              input logic [BYTE_W-1:0] b,
                                              input logic [BYTE_W-1:0] c);
    logic signed [BYTE_W+1:0] sa, sb, sc, da, db, dc;
    logic signed [BYTE_W+1:0] pa, pb, pc;
    sa = $signed({2'b00, a});
    sb = $signed({2'b00, b});
    sc = $signed({2'b00, c});
    // p - a = b - c, p - b = a - c, p - c = a + b - 2c
    da = sb - sc;
    db = sa - sc;
    dc = sa + sb - sc - sc;
    pa = (da < 0) ? -da : da;
    pb = (db < 0) ? -db : db;
    pc = (dc < 0) ? -dc : dc;
    if (pa <= pb && pa <= pc) begin
      return a;
    end else if (pb <= pc) begin
      return b;
    end else begin
      return c;
    end
  endfunction

endpackage

// ----- hw/rtl/png_scanline_unfilter_top.sv -----
// PNG scanline unfilter, top level: stream ports, APB registers, front,
// queue and back. Depends on psu_pkg, psu_front, psu_fifo, psu_back, psu_ram.
//
// Takes the inflated PNG byte stream one item per cycle. The first item of
// each row is the filter type (a code above Paeth is treated as None); the
// next row_bytes items are filtered data, each rebuilt with None, Sub, Up,
// Average or Paeth and sent out with tlast on the last byte of the row.
// tuser high on an input item marks the filter byte of the first row of a
// new pass; that row sees zeros above it, and an unfinished row is dropped.
// Rate: one item per cycle sustained, filter bytes included (they give no
// output). A data byte is written into the queue when it is taken, moves
// to the working stage (row-above read in the prior-row RAM) and then into
// the result register that drives its output item. The input stalls only
// when the two-entry queue fills behind a stalled output. Registers (APB,
// to be written by the user only while the block is idle; the block itself
// does not enforce this): 0x0 bytes_per_pixel (1..MAX_PIXEL_BYTES, clamped),
// 0x4 row_bytes (1..MAX_ROW_BYTES, clamped). Raising row_bytes within a
// pass leaves unwritten columns of the row above undefined.
module png_scanline_unfilter_top #(
  parameter int unsigned MAX_ROW_BYTES   = 16384,
  parameter int unsigned MAX_PIXEL_BYTES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] pass_start
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] recon_byte
  output logic        m_axis_tlast,   // row_end
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AW = $clog2(MAX_ROW_BYTES);
  localparam int unsigned EW = $bits(psu_pkg::entry_t);

  localparam logic REG_BPP       = 1'b0;
  localparam logic REG_ROW_BYTES = 1'b1;

  // ---- configuration registers ----
  logic [psu_pkg::BPP_W-1:0]       bpp_q;
  logic [psu_pkg::ROW_BYTES_W-1:0] row_bytes_q;
  logic                            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q       <= psu_pkg::BPP_W'(1);
      row_bytes_q <= psu_pkg::ROW_BYTES_W'(1);
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_BPP:       bpp_q       <= pwdata[psu_pkg::BPP_W-1:0];
        REG_ROW_BYTES: row_bytes_q <= pwdata[psu_pkg::ROW_BYTES_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_BPP:       prdata = 32'(bpp_q);
      REG_ROW_BYTES: prdata = 32'(row_bytes_q);
      default:       prdata = '0;
    endcase
  end

  // ---- front: classify bytes, track row position ----
  logic            q_full, q_empty, q_push, q_pop;
  logic            in_accept;
  psu_pkg::entry_t f_entry, b_entry;
  logic [AW-1:0]   f_column, b_column;

  assign s_axis_tready = ~q_full;
  assign in_accept     = s_axis_tvalid & ~q_full;

  psu_front #(
    .MAX_ROW_BYTES(MAX_ROW_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .data_byte_i (s_axis_tdata),
    .pass_start_i(s_axis_tuser),
    .row_bytes_i (row_bytes_q),
    .push_o      (q_push),
    .entry_o     (f_entry),
    .column_o    (f_column)
  );

  // ---- queue: data bytes with their column ----
  logic [AW+EW-1:0] q_wdata, q_rdata;

  assign q_wdata  = {f_column, f_entry};
  assign b_entry  = q_rdata[EW-1:0];
  assign b_column = q_rdata[AW+EW-1:EW];

  psu_fifo #(
    .WIDTH(AW + EW)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i(q_wdata),
    .pop_i      (q_pop),
    .pop_data_o (q_rdata),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  // ---- back: reconstruct and drive the output stream ----
  psu_back #(
    .MAX_ROW_BYTES  (MAX_ROW_BYTES),
    .MAX_PIXEL_BYTES(MAX_PIXEL_BYTES)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_empty_i        (q_empty),
    .q_entry_i        (b_entry),
    .q_column_i       (b_column),
    .q_pop_o          (q_pop),
    .bytes_per_pixel_i(bpp_q),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .recon_byte_o     (m_axis_tdata),
    .row_end_o        (m_axis_tlast)
  );

endmodule

// ----- hw/rtl/psu_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies; no reset, contents undefined until written.
module psu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- hw/rtl/psu_fifo.sv -----
// Two-entry queue between the front and the back of the unfilter.
// No dependencies; push and pop may happen in the same cycle.
module psu_fifo #(
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             full_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o = mem_q[rd_ptr_q];
  assign full_o     = (count_q == 2'd2);
  assign empty_o    = (count_q == 2'd0);

endmodule

// ----- hw/rtl/psu_front.sv -----
// Front end: takes stream bytes, splits filter bytes from data bytes and
// tracks row position. Depends on psu_pkg.
module psu_front #(
  parameter int unsigned MAX_ROW_BYTES = 16384
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  accept_i,
  input  logic [psu_pkg::BYTE_W-1:0]            data_byte_i,
  input  logic                                  pass_start_i,
  input  logic [psu_pkg::ROW_BYTES_W-1:0]       row_bytes_i,
  output logic                                  push_o,
  output psu_pkg::entry_t                       entry_o,
  output logic [$clog2(MAX_ROW_BYTES)-1:0]      column_o
);

  localparam int unsigned AW   = $clog2(MAX_ROW_BYTES);
  localparam int unsigned CMPW = (AW + 1 > psu_pkg::ROW_BYTES_W) ? AW + 1
                                                                 : psu_pkg::ROW_BYTES_W;

  logic [AW-1:0]    column_q, column_d;
  psu_pkg::filter_e filter_q, filter_d;
  logic             awaiting_q, awaiting_d;
  logic             first_row_q, first_row_d;

  logic [CMPW-1:0]  rb_raw, rb_eff, next_col;
  logic             is_filter, row_end;

  assign rb_raw = CMPW'(row_bytes_i);

  always_comb begin
    if (rb_raw == '0) begin
      rb_eff = CMPW'(1);
    end else if (rb_raw > CMPW'(MAX_ROW_BYTES)) begin
      rb_eff = CMPW'(MAX_ROW_BYTES);
    end else begin
      rb_eff = rb_raw;
    end
  end

  assign next_col  = CMPW'(column_q) + CMPW'(1);
  assign row_end   = (next_col >= rb_eff);
  assign is_filter = pass_start_i | awaiting_q;

  always_comb begin
    column_d    = column_q;
    filter_d    = filter_q;
    awaiting_d  = awaiting_q;
    first_row_d = first_row_q;
    if (accept_i) begin
      if (is_filter) begin
        filter_d   = (data_byte_i > psu_pkg::BYTE_W'(psu_pkg::FILT_PAETH))
                     ? psu_pkg::FILT_NONE : psu_pkg::filter_e'(data_byte_i[2:0]);
        awaiting_d = 1'b0;
        column_d   = '0;
        if (pass_start_i) begin
          first_row_d = 1'b1;
        end
      end else if (row_end) begin
        column_d    = '0;
        awaiting_d  = 1'b1;
        first_row_d = 1'b0;
      end else begin
        column_d = next_col[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q    <= '0;
      filter_q    <= psu_pkg::FILT_NONE;
      awaiting_q  <= 1'b1;
      first_row_q <= 1'b1;
    end else begin
      column_q    <= column_d;
      filter_q    <= filter_d;
      awaiting_q  <= awaiting_d;
      first_row_q <= first_row_d;
    end
  end

  assign push_o              = accept_i & ~is_filter;
  assign entry_o.data        = data_byte_i;
  assign entry_o.filter      = filter_q;
  assign entry_o.first_row   = first_row_q;
  assign entry_o.row_end     = row_end;
  assign column_o            = column_q;

endmodule

// ----- hw/rtl/psu_back.sv -----
// Back end: reads the row above, rebuilds each data byte and holds the
// result for the output stream. Depends on psu_pkg and psu_ram.
module psu_back #(
  parameter int unsigned MAX_ROW_BYTES   = 16384,
  parameter int unsigned MAX_PIXEL_BYTES = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               q_empty_i,
  input  psu_pkg::entry_t                    q_entry_i,
  input  logic [$clog2(MAX_ROW_BYTES)-1:0]   q_column_i,
  output logic                               q_pop_o,
  input  logic [psu_pkg::BPP_W-1:0]          bytes_per_pixel_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [psu_pkg::BYTE_W-1:0]         recon_byte_o,
  output logic                               row_end_o
);

  localparam int unsigned AW = $clog2(MAX_ROW_BYTES);
  localparam int unsigned IW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
  localparam int unsigned BW = psu_pkg::BYTE_W;

  // working stage
  logic            s1_valid_q, s1_valid_d;
  psu_pkg::entry_t s1_entry_q;
  logic [AW-1:0]   s1_col_q;
  logic            fwd_q;
  logic [BW-1:0]   fwd_data_q;
  logic            s1_adv;

  // output register
  logic            out_valid_q, out_valid_d;
  logic [BW-1:0]   out_data_q;
  logic            out_last_q;

  logic [BW-1:0]   left_q  [MAX_PIXEL_BYTES];
  logic [BW-1:0]   upper_q [MAX_PIXEL_BYTES];

  logic [BW-1:0]   ram_rd, up_byte, a, b, c, add, recon;
  logic [psu_pkg::BPP_W-1:0] bpp_eff, bpp_m1;
  logic [IW-1:0]   sel;
  logic            has_left;

  assign s1_adv  = s1_valid_q & (~out_valid_q | out_ready_i);
  assign q_pop_o = ~q_empty_i & (~s1_valid_q | s1_adv);

  psu_ram #(
    .WIDTH(BW),
    .DEPTH(MAX_ROW_BYTES)
  ) u_prior_row (
    .clk_i    (clk_i),
    .wr_en_i  (s1_adv),
    .wr_addr_i(s1_col_q),
    .wr_data_i(recon),
    .rd_en_i  (q_pop_o),
    .rd_addr_i(q_column_i),
    .rd_data_o(ram_rd)
  );

  always_comb begin
    if (bytes_per_pixel_i == '0) begin
      bpp_eff = psu_pkg::BPP_W'(1);
    end else if (bytes_per_pixel_i > psu_pkg::BPP_W'(MAX_PIXEL_BYTES)) begin
      bpp_eff = psu_pkg::BPP_W'(MAX_PIXEL_BYTES);
    end else begin
      bpp_eff = bytes_per_pixel_i;
    end
  end

  assign bpp_m1   = bpp_eff - psu_pkg::BPP_W'(1);
  assign sel      = bpp_m1[IW-1:0];
  // left history only counts bytes of this row: neighbors left of column bpp read zero
  assign has_left = (s1_col_q >= AW'(bpp_eff));

  assign up_byte = fwd_q ? fwd_data_q : ram_rd;
  assign b       = s1_entry_q.first_row ? '0 : up_byte;
  assign a       = has_left ? left_q[sel]  : '0;
  assign c       = has_left ? upper_q[sel] : '0;

  always_comb begin
    unique case (s1_entry_q.filter)
      psu_pkg::FILT_SUB:   add = a;
      psu_pkg::FILT_UP:    add = b;
      psu_pkg::FILT_AVG:   add = BW'(({1'b0, a} + {1'b0, b}) >> 1);
      psu_pkg::FILT_PAETH: add = psu_pkg::paeth(a, b, c);
      default:             add = '0;
    endcase
  end

  assign recon = s1_entry_q.data + add;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (q_pop_o) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      s1_entry_q <= q_entry_i;
      s1_col_q   <= q_column_i;
      // same column written this cycle: RAM returns stale data, take the new byte
      fwd_q      <= s1_adv & (s1_col_q == q_column_i);
      fwd_data_q <= recon;
    end
    if (s1_adv) begin
      out_data_q <= recon;
      out_last_q <= s1_entry_q.row_end;
      left_q[0]  <= recon;
      upper_q[0] <= b;
      for (int k = 1; k < MAX_PIXEL_BYTES; k++) begin
        left_q[k]  <= left_q[k-1];
        upper_q[k] <= upper_q[k-1];
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign recon_byte_o = out_data_q;
  assign row_end_o    = out_last_q;

endmodule

// ----- bench/png_scanline_unfilter_top_tb.sv -----
// Self-checking bench for png_scanline_unfilter_top: a directed table, then random passes.
// An in-bench predictor of the PNG row unfilter checks every output item.
// Depends on psu_pkg and the RTL of png_scanline_unfilter_top.
module png_scanline_unfilter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_ROW_BYTES    = 16384;
  localparam int unsigned MAX_PIXEL_BYTES  = 8;
  localparam int unsigned RANDOM_ITEMS     = 300;
  localparam int unsigned CALM_ROW_BYTES   = 40;
  localparam int unsigned SETTLE_CYCLES    = 8;      // output pipe is three deep
  localparam int unsigned LONG_HOLD_AT     = 120;    // output items seen before the long stall
  localparam int unsigned LONG_HOLD_CYCLES = 64;
  localparam int unsigned CYCLE_LIMIT      = 1000000;

  typedef logic [7:0] byte_t;

  // Filter codes past Paeth; the block folds them to None.
  localparam byte_t BAD_FILTER_LO = 8'd5;
  localparam byte_t BAD_FILTER_HI = 8'hFF;

  // APB byte addresses of the two registers.
  typedef enum logic [2:0] {
    REG_BPP       = 3'h0,
    REG_ROW_BYTES = 3'h4
  } reg_addr_e;

  typedef struct packed {
    byte_t recon;
    logic  row_end;
  } recon_t;

  typedef enum logic [1:0] {
    DIR_BYTE,
    DIR_SET_BPP,
    DIR_SET_ROW
  } dir_op_e;

  typedef struct {
    dir_op_e     op;
    logic [31:0] val;
    bit          ps;
    bit          typed;
    recon_t      want;
  } dir_row_t;

  // ---------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // [7:0] data_byte
  logic        s_axis_tuser  = 1'b0; // [0] pass_start
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;         // [7:0] recon_byte
  logic        m_axis_tlast;         // row_end
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  png_scanline_unfilter_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: registers, row above, left and upper-left history
  // ---------------------------------------------------------------------------
  logic [3:0]       bpp_reg        = 4'd1;
  logic [14:0]      row_bytes_reg  = 15'd1;
  byte_t            above_row   [MAX_ROW_BYTES];
  byte_t            left_hist   [MAX_PIXEL_BYTES];
  byte_t            upleft_hist [MAX_PIXEL_BYTES];
  int unsigned      col_idx        = 0;
  psu_pkg::filter_e cur_filter     = psu_pkg::FILT_NONE;
  bit               want_filter    = 1'b1;
  bit               pass_first_row = 1'b1;

  recon_t      pending_recon [$];   // expected output items, oldest first
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  bit          calm           = 1'b0; // no idling on either side when set

  initial begin
    foreach (above_row[i]) above_row[i] = '0;
    foreach (left_hist[i]) begin
      left_hist[i]   = '0;
      upleft_hist[i] = '0;
    end
  end

  // Rebuild one accepted stream byte; returns 1 when it yields an output item.
  function automatic bit unfilter_byte(input byte_t d, input bit ps, output recon_t r);
    int unsigned bpp, rb, x;
    int          p, pa, pb, pc;
    byte_t       a, b, c, add;
    r = '0;
    // filter byte: new row, or a new pass that drops any unfinished row
    if (ps || want_filter) begin
      cur_filter  = (d > 8'(psu_pkg::FILT_PAETH)) ? psu_pkg::FILT_NONE
                                                  : psu_pkg::filter_e'(d[2:0]);
      want_filter = 1'b0;
      if (ps) pass_first_row = 1'b1;
      col_idx = 0;
      foreach (left_hist[k]) begin
        left_hist[k]   = '0;
        upleft_hist[k] = '0;
      end
      return 1'b0;
    end

    // registers are clamped to the legal ranges
    bpp = int'(bpp_reg);
    if (bpp < 1) bpp = 1;
    if (bpp > MAX_PIXEL_BYTES) bpp = MAX_PIXEL_BYTES;
    rb = int'(row_bytes_reg);
    if (rb < 1) rb = 1;
    if (rb > MAX_ROW_BYTES) rb = MAX_ROW_BYTES;
    x = col_idx;
    if (x >= MAX_ROW_BYTES) x = MAX_ROW_BYTES - 1;

    a = left_hist[bpp-1];
    c = upleft_hist[bpp-1];
    b = pass_first_row ? 8'h00 : above_row[x];

    case (cur_filter)
      psu_pkg::FILT_SUB:   add = a;
      psu_pkg::FILT_UP:    add = b;
      psu_pkg::FILT_AVG:   add = byte_t'((int'(a) + int'(b)) >> 1);
      psu_pkg::FILT_PAETH: begin
        // ties go to a, then b, then c
        p  = int'(a) + int'(b) - int'(c);
        pa = (p > int'(a)) ? p - int'(a) : int'(a) - p;
        pb = (p > int'(b)) ? p - int'(b) : int'(b) - p;
        pc = (p > int'(c)) ? p - int'(c) : int'(c) - p;
        if (pa <= pb && pa <= pc) add = a;
        else if (pb <= pc) add = b;
        else add = c;
      end
      default:             add = '0;
    endcase
    r.recon = d + add;

    for (int k = MAX_PIXEL_BYTES - 1; k > 0; k--) begin
      left_hist[k]   = left_hist[k-1];
      upleft_hist[k] = upleft_hist[k-1];
    end
    left_hist[0]   = r.recon;
    upleft_hist[0] = b;
    above_row[x]   = r.recon;

    r.row_end = (x + 1 >= rb);
    if (r.row_end) begin
      col_idx        = 0;
      want_filter    = 1'b1;
      pass_first_row = 1'b0;
    end else begin
      col_idx = x + 1;
    end
    return 1'b1;
  endfunction

  function automatic byte_t random_filter();
    if ($urandom_range(0, 9) == 0)
      return byte_t'($urandom_range(int'(BAD_FILTER_LO), int'(BAD_FILTER_HI)));
    return byte_t'($urandom_range(int'(psu_pkg::FILT_NONE), int'(psu_pkg::FILT_PAETH)));
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus side
  // ---------------------------------------------------------------------------

  // Offer one input item, sometimes after a random gap, and predict its outcome.
  // A typed expectation replaces the predicted one for table rows.
  task automatic send_byte(input byte_t d, input bit ps,
                           input bit typed = 1'b0, input recon_t typed_res = '0);
    recon_t r;
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= ps;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    if (unfilter_byte(d, ps, r)) pending_recon.push_back(typed ? typed_res : r);
  endtask

  // Stop offering and wait until every expected item is out, then let the pipe
  // drain (a trailing filter byte may still be in flight).
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_recon.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // APB write: setup, access, then an idle phase so writes never abut.
  task automatic reg_write(input reg_addr_e addr, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    case (addr)
      REG_BPP:       bpp_reg       = v[3:0];
      REG_ROW_BYTES: row_bytes_reg = v[14:0];
      default:       ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // One pass with random settings: well-formed rows with random content,
  // sprinkled with pass restarts in mid-row.
  task automatic run_random_pass(input int unsigned budget);
    logic [31:0] bpp_v, rb_v;
    int unsigned rb_eff, col, sent;
    case ($urandom_range(0, 9))
      0:       bpp_v = 32'd0;
      1:       bpp_v = $urandom_range(9, 15);
      default: bpp_v = $urandom_range(1, MAX_PIXEL_BYTES);
    endcase
    case ($urandom_range(0, 19))
      0:       rb_v = 32'd0;
      1, 2:    rb_v = $urandom_range(21, 80);
      default: rb_v = $urandom_range(1, 20);
    endcase
    rb_eff = (rb_v == 0) ? 1 : rb_v;

    settle();
    reg_write(REG_BPP, bpp_v);
    reg_write(REG_ROW_BYTES, rb_v);

    // new settings always open a new pass so the row above is fully written
    send_byte(random_filter(), 1'b1);
    sent = 1;
    col  = 0;
    while (sent < budget) begin
      if (col == rb_eff) begin
        send_byte(random_filter(), 1'b0);
        col = 0;
      end else if ($urandom_range(0, 39) == 0) begin
        send_byte(random_filter(), 1'b1);
        col = 0;
      end else begin
        send_byte(byte_t'($urandom_range(0, 255)), 1'b0);
        col++;
      end
      sent++;
    end
  endtask

  // Directed table. Rows marked typed carry an expectation read straight off
  // the filter rules; the rest go through the predictor.
  localparam int DIR_ROWS = 31;
  dir_row_t dir_tab [DIR_ROWS] = '{
    // reset settings: one pixel byte, one byte per row
    '{DIR_BYTE,    32'(psu_pkg::FILT_NONE),  1'b1, 1'b0, '0},
    '{DIR_BYTE,    32'hFF,                   1'b0, 1'b1, '{8'hFF, 1'b1}},
    '{DIR_BYTE,    32'(psu_pkg::FILT_UP),    1'b0, 1'b0, '0},
    '{DIR_BYTE,    32'h01,                   1'b0, 1'b1, '{8'h00, 1'b1}},  // wraps mod 256
    '{DIR_BYTE,    32'(BAD_FILTER_HI),       1'b0, 1'b0, '0},  // unknown code -> None
    '{DIR_BYTE,    32'h80,                   1'b0, 1'b1, '{8'h80, 1'b1}},
    // bpp of zero clamps to one; two bytes per row
    '{DIR_SET_BPP, 32'h0,                    1'b0, 1'b0, '0},
    '{DIR_SET_ROW, 32'h2,                    1'b0, 1'b0, '0},
    '{DIR_BYTE,    32'(psu_pkg::FILT_SUB),   1'b1, 1'b0, '0},
    '{DIR_BYTE,    32'h0A,                   1'b0, 1'b1, '{8'h0A, 1'b0}},
    '{DIR_BYTE,    32'h14,                   1'b0, 1'b1, '{8'h1E, 1'b1}},
    '{DIR_BYTE,    32'(psu_pkg::FILT_AVG),   1'b0, 1'b0, '0},
    '{DIR_BYTE,    32'h01,                   1'b0, 1'b0, '0},
    '{DIR_BYTE,    32'h02,                   1'b0, 1'b0, '0},
    '{DIR_BYTE,    32'(psu_pkg::FILT_PAETH), 1'b0, 1'b0, '0},
    '{DIR_BYTE,    32'hFF,                   1'b0, 1'b0, '0},
    '{DIR_BYTE,    32'h80,                   1'b0, 1'b0, '0},
    '{DIR_BYTE,    32'(psu_pkg::FILT_UP),    1'b0, 1'b0, '0},
    '{DIR_BYTE,    32'h05,                   1'b0, 1'b0, '0},
    // pass restart mid-row: row dropped, Up sees zeros above
    '{DIR_BYTE,    32'(psu_pkg::FILT_UP),    1'b1, 1'b0, '0},
    '{DIR_BYTE,    32'h07,                   1'b0, 1'b1, '{8'h07, 1'b0}},
    '{DIR_BYTE,    32'h08,                   1'b0, 1'b1, '{8'h08, 1'b1}},
    // bpp above range clamps to eight; first row of Paeth adds nothing
    '{DIR_SET_BPP, 32'hF,                    1'b0, 1'b0, '0},
    '{DIR_SET_ROW, 32'h6,                    1'b0, 1'b0, '0},
    '{DIR_BYTE,    32'(psu_pkg::FILT_PAETH), 1'b1, 1'b0, '0},
    '{DIR_BYTE,    32'h00,                   1'b0, 1'b1, '{8'h00, 1'b0}},
    '{DIR_BYTE,    32'hFF,                   1'b0, 1'b1, '{8'hFF, 1'b0}},
    '{DIR_BYTE,    32'h55,                   1'b0, 1'b1, '{8'h55, 1'b0}},
    '{DIR_BYTE,    32'hAA,                   1'b0, 1'b1, '{8'hAA, 1'b0}},
    // row length cut below the current column: the next byte ends the row
    '{DIR_SET_ROW, 32'h2,                    1'b0, 1'b0, '0},
    '{DIR_BYTE,    32'h3C,                   1'b0, 1'b0, '0}
  };

  initial begin : stimulus
    int unsigned random_items, budget;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) begin
      case (dir_tab[i].op)
        DIR_SET_BPP: begin
          settle();
          reg_write(REG_BPP, dir_tab[i].val);
        end
        DIR_SET_ROW: begin
          settle();
          reg_write(REG_ROW_BYTES, dir_tab[i].val);
        end
        default: begin
          send_byte(byte_t'(dir_tab[i].val), dir_tab[i].ps, dir_tab[i].typed,
                    dir_tab[i].want);
        end
      endcase
    end

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      budget = $urandom_range(30, 80);
      run_random_pass(budget);
      random_items += budget;
    end

    // Last part, no idling: eight pixel bytes (register above range clamps),
    // a Sub row then a Paeth row reading it.
    calm = 1'b1;
    settle();
    reg_write(REG_BPP, 32'hF);
    reg_write(REG_ROW_BYTES, 32'(CALM_ROW_BYTES));
    send_byte(byte_t'(psu_pkg::FILT_SUB), 1'b1);
    repeat (CALM_ROW_BYTES) send_byte(byte_t'($urandom_range(0, 255)), 1'b0);
    send_byte(byte_t'(psu_pkg::FILT_PAETH), 1'b0);
    repeat (CALM_ROW_BYTES) send_byte(byte_t'($urandom_range(0, 255)), 1'b0);

    settle();
    if (mismatch_count == 0) begin
      $display("png_scanline_unfilter_top_tb: PASS");
    end else begin
      $display("png_scanline_unfilter_top_tb: FAIL");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Output side: random ready, one long stall, and the checker
  // ---------------------------------------------------------------------------
  initial begin : result_side
    int unsigned hold_left, taken;
    bit          long_hold_done;
    recon_t      want;
    hold_left      = 0;
    taken          = 0;
    long_hold_done = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
        taken++;
        if (pending_recon.size() == 0) begin
          $error("unexpected output item: recon_byte %02h row_end %0b",
                 m_axis_tdata, m_axis_tlast);
          mismatch_count++;
        end else begin
          want = pending_recon.pop_front();
          if (m_axis_tdata !== want.recon) begin
            $error("recon_byte: expected %02h, got %02h", want.recon, m_axis_tdata);
            mismatch_count++;
          end
          if (m_axis_tlast !== want.row_end) begin
            $error("row_end: expected %0b, got %0b", want.row_end, m_axis_tlast);
            mismatch_count++;
          end
        end
      end

      // the long stall fills the internal queue so the input has to back off
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!long_hold_done && taken >= LONG_HOLD_AT) begin
        long_hold_done = 1'b1;
        hold_left      = LONG_HOLD_CYCLES - 1;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        hold_left      = $urandom_range(0, 3);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $error("run did not finish within %0d cycles", CYCLE_LIMIT);
    $display("png_scanline_unfilter_top_tb: FAIL");
    $finish;
  end

endmodule
